FILE: src/assert_macros.svh
// assertion macros used by the checker file sfr_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// clocked assertion on the usual clk_i and rst_ni
`define ASSERT_STD(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

FILE: src/sfr_pkg.sv
// constants and types of the sbus frame receiver
// no dependencies
package sfr_pkg;

  localparam logic [7:0] HeaderByte      = 8'h0F;
  localparam logic [7:0] FooterByte      = 8'h00;
  localparam int         PayloadLen      = 23;
  localparam int         ChanBytes       = 22;
  localparam int         NumChans        = 16;
  localparam int         ChanWidth       = 11;
  localparam int         ChanIdxWidth    = 4;
  localparam int         AddrWidth       = $clog2(PayloadLen);
  localparam int         AccWidth        = ChanWidth + 7;
  localparam int         CntWidth        = $clog2(AccWidth + 1);
  localparam int         FlagFailsafeBit = 3;
  localparam int         FlagLostBit     = 2;
  localparam logic [7:0] MinGoodReset    = 8'd2;

  typedef enum logic [2:0] {
    FR_HUNT    = 3'b001,
    FR_PAYLOAD = 3'b010,
    FR_FOOTER  = 3'b100
  } sfr_frame_e;

  typedef enum logic [1:0] {
    UN_IDLE = 2'b01,
    UN_RUN  = 2'b10
  } sfr_unpack_e;

  typedef struct packed {
    logic start;
    logic failsafe;
    logic frame_lost;
  } sfr_start_t;

endpackage

FILE: src/sfr_payload_ram.sv
// payload byte store, one write port and one registered read port
// depends on sfr_pkg
module sfr_payload_ram import sfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [7:0]           wdata_i,
  input  logic                 re_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [7:0]           rdata_o
);

  logic [7:0] mem_q [PayloadLen];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/sfr_frame_fsm.sv
// frame sync: header hunt, payload write, footer check, good-frame count
// depends on sfr_pkg
module sfr_frame_fsm import sfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 rx_valid_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 busy_i,
  output logic                 wr_en_o,
  output logic [AddrWidth-1:0] wr_addr_o,
  output sfr_start_t           start_o
);

  sfr_frame_e           state_q, state_d;
  logic [AddrWidth-1:0] pos_q, pos_d;
  logic [7:0]           prev_q;
  logic [7:0]           good_q, good_d;
  logic [7:0]           min_good_q;
  logic                 failsafe_q, failsafe_d;
  logic                 lost_q, lost_d;
  logic                 accept;
  logic [7:0]           good_inc;

  assign accept   = rx_valid_i && !busy_i;
  assign good_inc = (good_q == 8'hFF) ? good_q : good_q + 8'd1;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    good_d     = good_q;
    failsafe_d = failsafe_q;
    lost_d     = lost_q;
    wr_en_o    = 1'b0;
    start_o    = '0;
    if (accept) begin
      unique case (state_q)
        FR_HUNT: begin
          if (rx_byte_i == HeaderByte && prev_q == FooterByte) begin
            state_d = FR_PAYLOAD;
            pos_d   = '0;
          end
        end
        FR_PAYLOAD: begin
          wr_en_o = 1'b1;
          if (pos_q == AddrWidth'(PayloadLen - 1)) begin
            state_d    = FR_FOOTER;
            failsafe_d = rx_byte_i[FlagFailsafeBit];
            lost_d     = rx_byte_i[FlagLostBit];
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
        FR_FOOTER: begin
          state_d = FR_HUNT;
          if (rx_byte_i == FooterByte) begin
            good_d = good_inc;
            if (good_inc > min_good_q) begin
              start_o.start = 1'b1;
            end
          end else begin
            good_d = '0;
          end
        end
        default: state_d = FR_HUNT;
      endcase
    end
    start_o.failsafe   = failsafe_q;
    start_o.frame_lost = lost_q;
  end

  assign wr_addr_o = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FR_HUNT;
      pos_q      <= '0;
      prev_q     <= '0;
      good_q     <= '0;
      min_good_q <= MinGoodReset;
      failsafe_q <= 1'b0;
      lost_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      good_q     <= good_d;
      failsafe_q <= failsafe_d;
      lost_q     <= lost_d;
      if (accept) begin
        prev_q <= rx_byte_i;
      end
      if (cfg_we_i) begin
        min_good_q <= cfg_wdata_i;
      end
    end
  end

endmodule

FILE: src/sfr_unpack.sv
// reads the payload back byte by byte and emits sixteen 11-bit channels
// depends on sfr_pkg
module sfr_unpack import sfr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sfr_start_t              start_i,
  output logic                    busy_o,
  output logic                    rd_en_o,
  output logic [AddrWidth-1:0]    rd_addr_o,
  input  logic [7:0]              rd_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ChanIdxWidth-1:0] channel_index_o,
  output logic [ChanWidth-1:0]    channel_value_o,
  output logic                    failsafe_o,
  output logic                    frame_lost_o,
  output logic                    last_o
);

  sfr_unpack_e             state_q, state_d;
  logic [AddrWidth-1:0]    addr_q, addr_d;
  logic                    inflight_q;
  logic [AccWidth-1:0]     acc_q, acc_d, acc_mid;
  logic [CntWidth-1:0]     cnt_q, cnt_d, cnt_mid;
  logic [ChanIdxWidth-1:0] ch_q, ch_d;
  logic                    fs_q, lost_q;
  logic                    out_valid_q;
  logic [ChanIdxWidth-1:0] out_idx_q;
  logic [ChanWidth-1:0]    out_val_q;
  logic                    out_fs_q, out_lost_q, out_last_q;
  logic                    out_free, emit, issue, run;

  assign run      = (state_q == UN_RUN);
  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = run && (cnt_q >= CntWidth'(ChanWidth)) && out_free;
  assign issue    = run && !inflight_q && (addr_q < AddrWidth'(ChanBytes))
                    && (cnt_q < CntWidth'(ChanWidth));

  always_comb begin
    state_d = state_q;
    addr_d  = addr_q;
    ch_d    = ch_q;
    cnt_mid = emit ? cnt_q - CntWidth'(ChanWidth) : cnt_q;
    acc_mid = emit ? acc_q >> ChanWidth : acc_q;
    acc_d   = acc_mid;
    cnt_d   = cnt_mid;
    if (inflight_q) begin
      acc_d = acc_mid | (AccWidth'(rd_data_i) << cnt_mid);
      cnt_d = cnt_mid + CntWidth'(8);
    end
    if (issue) begin
      addr_d = addr_q + 1'b1;
    end
    if (emit) begin
      ch_d = ch_q + 1'b1;
      if (ch_q == ChanIdxWidth'(NumChans - 1)) begin
        state_d = UN_IDLE;
      end
    end
    if (start_i.start) begin
      state_d = UN_RUN;
      addr_d  = '0;
      ch_d    = '0;
      acc_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= UN_IDLE;
      addr_q      <= '0;
      inflight_q  <= 1'b0;
      cnt_q       <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      addr_q     <= addr_d;
      inflight_q <= issue;
      cnt_q      <= cnt_d;
      ch_q       <= ch_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i.start) begin
      fs_q   <= start_i.failsafe;
      lost_q <= start_i.frame_lost;
    end
    if (emit) begin
      out_idx_q  <= ch_q;
      out_val_q  <= acc_q[ChanWidth-1:0];
      out_fs_q   <= fs_q;
      out_lost_q <= lost_q;
      out_last_q <= (ch_q == ChanIdxWidth'(NumChans - 1));
    end
  end

  assign busy_o          = run;
  assign rd_en_o         = issue;
  assign rd_addr_o       = addr_q;
  assign out_valid_o     = out_valid_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign failsafe_o      = out_fs_q;
  assign frame_lost_o    = out_lost_q;
  assign last_o          = out_last_q;

endmodule

FILE: src/sbus_frame_receiver_unit.sv
// top level of the sbus frame receiver: frame sync, payload store, unpacker
// depends on sfr_pkg, sfr_frame_fsm, sfr_payload_ram, sfr_unpack
//
//  port group   direction  handshake              payload
//  rx           in         rx_valid_i/rx_stall_o  rx_byte_i
//  out          out        out_valid_o/out_stall_i channel_index_o .. last_o
//  cfg          in         cfg_we_i               cfg_wdata_i (min good frames)
//
// a byte other than a delivering footer does not hold the input
// a delivering footer holds the input while the unpacker reads the 22 channel
//   bytes from the payload store and emits 16 words
// rx_stall_o is high while the sixteen channels are being unpacked
// out_stall_i holds the output register and pauses the unpacker
// reset clears the framing, the good-frame count and sets the threshold to 2
module sbus_frame_receiver_unit import sfr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [7:0]              cfg_wdata_i,
  input  logic                    rx_valid_i,
  output logic                    rx_stall_o,
  input  logic [7:0]              rx_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [ChanIdxWidth-1:0] channel_index_o,
  output logic [ChanWidth-1:0]    channel_value_o,
  output logic                    failsafe_o,
  output logic                    frame_lost_o,
  output logic                    last_o
);

  logic                 busy;
  logic                 wr_en;
  logic [AddrWidth-1:0] wr_addr;
  logic                 rd_en;
  logic [AddrWidth-1:0] rd_addr;
  logic [7:0]           rd_data;
  sfr_start_t           start;

  sfr_frame_fsm u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_valid_i),
    .rx_byte_i   (rx_byte_i),
    .busy_i      (busy),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .start_o     (start)
  );

  sfr_payload_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (rx_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  sfr_unpack u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .failsafe_o      (failsafe_o),
    .frame_lost_o    (frame_lost_o),
    .last_o          (last_o)
  );

  assign rx_stall_o = busy;

endmodule

FILE: src/sfr_checker.sv
// port-level checks for the sbus frame receiver, bound to the top level
// depends on sfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module sfr_checker import sfr_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_we_i,
  input logic [7:0]              cfg_wdata_i,
  input logic                    rx_valid_i,
  input logic                    rx_stall_o,
  input logic [7:0]              rx_byte_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [ChanIdxWidth-1:0] channel_index_o,
  input logic [ChanWidth-1:0]    channel_value_o,
  input logic                    failsafe_o,
  input logic                    frame_lost_o,
  input logic                    last_o
);

  // a stalled output word holds
  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(channel_value_o))
  // last marks channel 15 and nothing else
  `ASSERT_STD(a_last_idx, out_valid_o && last_o |-> channel_index_o == 4'(NumChans - 1))
  `ASSERT_STD(a_idx_last, out_valid_o && channel_index_o == 4'(NumChans - 1) |-> last_o)
  // unpacking only starts on an accepted byte
  `ASSERT_STD(a_stall_start, $rose(rx_stall_o) |-> $past(rx_valid_i && !rx_stall_o))

endmodule

bind sbus_frame_receiver_unit sfr_checker u_sfr_checker (.*);
